// ----- sv/image_rotate_nearest_top_assert.svh -----
// Assertion helpers for the rotation block.
`ifndef IMAGE_ROTATE_NEAREST_TOP_ASSERT_SVH
`define IMAGE_ROTATE_NEAREST_TOP_ASSERT_SVH

// ante must imply cons at the same edge
`define IRN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("irn: implication check failed");

// cond must never hold
`define IRN_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("irn: forbidden condition seen");

`endif

// ----- sv/irn_pkg.sv -----
`timescale 1ns / 1ps

package irn_pkg;

  localparam int MaxCols  = 256;
  localparam int MaxRows  = 256;
  localparam int Channels = 3;

  localparam int ColW   = $clog2(MaxCols);
  localparam int RowW   = $clog2(MaxRows);
  localparam int AddrW  = ColW + RowW;
  localparam int Depth  = MaxCols * MaxRows;
  localparam int ChanW  = 16;
  localparam int PixW   = 3 * ChanW;
  localparam int CoefW  = 16;
  localparam int SizeW  = 9;
  localparam int PosW   = 8;
  localparam int DiffW  = PosW + 1;
  localparam int ProdW  = CoefW + DiffW;
  localparam int FracW  = 12;
  localparam int FracOne = 1 << FracW;
  localparam int SumW   = ProdW + 2;
  localparam int CoordW = SumW - 1 - FracW;

  localparam logic signed [SumW-1:0] SumNegOne = SumW'(-FracOne);

  // channels at or above Channels are forced to zero
  localparam logic [PixW-1:0] ChanMask =
      (Channels >= 3) ? {PixW{1'b1}} :
      (Channels == 2) ? PixW'({2*ChanW{1'b1}}) : PixW'({ChanW{1'b1}});

  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = PixW;

  typedef enum logic {
    OpLoad  = 1'b0,
    OpFetch = 1'b1
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCoefCos   = 3'd0,
    CfgCoefSin   = 3'd1,
    CfgCentreCol = 3'd2,
    CfgCentreRow = 3'd3,
    CfgImageCols = 3'd4,
    CfgImageRows = 3'd5,
    CfgFillPixel = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [CoefW-1:0] coef_cos;
    logic [CoefW-1:0] coef_sin;
    logic [PosW-1:0]  centre_col;
    logic [PosW-1:0]  centre_row;
    logic [SizeW-1:0] image_cols;
    logic [SizeW-1:0] image_rows;
    logic [PixW-1:0]  fill_pixel;
  } cfg_t;

  typedef struct packed {
    opcode_e          op;
    logic             in_img;
    logic [AddrW-1:0] addr;
    logic [PixW-1:0]  data;
  } q_item_t;

  typedef struct packed {
    logic             valid;
    logic             full;
    logic [QCntW-1:0] count;
  } q_stat_t;

endpackage

// ----- sv/irn_front.sv -----
`timescale 1ns / 1ps

module irn_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  irn_pkg::cfg_t          cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   opcode_i,
  input  logic [7:0]             col_i,
  input  logic [7:0]             row_i,
  input  logic signed [15:0]     load_ch0_i,
  input  logic signed [15:0]     load_ch1_i,
  input  logic signed [15:0]     load_ch2_i,
  input  irn_pkg::q_stat_t       q_stat_i,
  output logic                   push_o,
  output irn_pkg::q_item_t       item_o
);

  logic                                a_valid_q, a_valid_d;
  irn_pkg::opcode_e                    a_op_q;
  logic [irn_pkg::PosW-1:0]            a_col_q, a_row_q;
  logic [irn_pkg::PixW-1:0]            a_data_q;
  logic signed [irn_pkg::ProdW-1:0]    p_cx_q, p_sy_q, p_sx_q, p_cy_q;

  logic                                accept;
  logic signed [irn_pkg::CoefW-1:0]    c, s;
  logic signed [irn_pkg::DiffW-1:0]    dx, dy;

  logic signed [irn_pkg::SumW-1:0]     cxs, cys, sx, sy;
  logic [irn_pkg::CoordW-1:0]          xs, ys;
  logic [irn_pkg::SizeW-1:0]           wc, wr;
  logic                                in_x, in_y;

  assign in_stall_o = a_valid_q && q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = a_valid_q && !q_stat_i.full;
  assign a_valid_d  = accept || (a_valid_q && q_stat_i.full);

  always_comb begin
    c  = cfg_i.coef_cos;
    s  = cfg_i.coef_sin;
    dx = $signed({1'b0, col_i}) - $signed({1'b0, cfg_i.centre_col});
    dy = $signed({1'b0, row_i}) - $signed({1'b0, cfg_i.centre_row});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  // stage A: four independent products
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_op_q   <= irn_pkg::opcode_e'(opcode_i);
      a_col_q  <= col_i;
      a_row_q  <= row_i;
      a_data_q <= {load_ch2_i, load_ch1_i, load_ch0_i} & irn_pkg::ChanMask;
      p_cx_q   <= c * dx;
      p_sy_q   <= s * dy;
      p_sx_q   <= s * dx;
      p_cy_q   <= c * dy;
    end
  end

  // stage B: add center, truncate toward zero, bounds check
  always_comb begin
    cxs = $signed({{(irn_pkg::SumW - irn_pkg::PosW - irn_pkg::FracW){1'b0}},
                   cfg_i.centre_col, {irn_pkg::FracW{1'b0}}});
    cys = $signed({{(irn_pkg::SumW - irn_pkg::PosW - irn_pkg::FracW){1'b0}},
                   cfg_i.centre_row, {irn_pkg::FracW{1'b0}}});
    sx  = irn_pkg::SumW'(p_cx_q) + irn_pkg::SumW'(p_sy_q) + cxs;
    sy  = irn_pkg::SumW'(p_cy_q) - irn_pkg::SumW'(p_sx_q) + cys;
    // values in (-1,0) truncate to zero
    xs  = sx[irn_pkg::SumW-1] ? '0 : sx[irn_pkg::SumW-2:irn_pkg::FracW];
    ys  = sy[irn_pkg::SumW-1] ? '0 : sy[irn_pkg::SumW-2:irn_pkg::FracW];
    wc  = (cfg_i.image_cols > irn_pkg::SizeW'(irn_pkg::MaxCols)) ?
          irn_pkg::SizeW'(irn_pkg::MaxCols) : cfg_i.image_cols;
    wr  = (cfg_i.image_rows > irn_pkg::SizeW'(irn_pkg::MaxRows)) ?
          irn_pkg::SizeW'(irn_pkg::MaxRows) : cfg_i.image_rows;
    in_x = (sx > irn_pkg::SumNegOne) && (xs < irn_pkg::CoordW'(wc));
    in_y = (sy > irn_pkg::SumNegOne) && (ys < irn_pkg::CoordW'(wr));

    item_o.op = a_op_q;
    if (a_op_q == irn_pkg::OpLoad) begin
      item_o.in_img = 1'b0;
      item_o.addr   = {a_row_q[irn_pkg::RowW-1:0], a_col_q[irn_pkg::ColW-1:0]};
      item_o.data   = a_data_q;
    end else begin
      item_o.in_img = in_x && in_y;
      item_o.addr   = {ys[irn_pkg::RowW-1:0], xs[irn_pkg::ColW-1:0]};
      item_o.data   = cfg_i.fill_pixel & irn_pkg::ChanMask;
    end
  end

endmodule

// ----- sv/irn_queue.sv -----
`timescale 1ns / 1ps

module irn_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  irn_pkg::q_item_t    item_i,
  input  logic                pop_i,
  output irn_pkg::q_item_t    item_o,
  output irn_pkg::q_stat_t    stat_o
);

  irn_pkg::q_item_t               slot_q [irn_pkg::QDepth];
  logic [irn_pkg::QPtrW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [irn_pkg::QCntW-1:0]      cnt_q, cnt_d;

  function automatic logic [irn_pkg::QPtrW-1:0] ptr_inc(
    input logic [irn_pkg::QPtrW-1:0] p
  );
    return (p == irn_pkg::QPtrW'(irn_pkg::QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o       = slot_q[rd_ptr_q];
  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.full  = (cnt_q == irn_pkg::QCntW'(irn_pkg::QDepth));
  assign stat_o.count = cnt_q;

endmodule

// ----- sv/irn_back.sv -----
`timescale 1ns / 1ps

module irn_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  irn_pkg::q_stat_t            q_stat_i,
  input  irn_pkg::q_item_t            item_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [irn_pkg::PixW-1:0]    out_pix_o,
  output logic                        inside_o
);

  logic [irn_pkg::PixW-1:0]  frame_mem [irn_pkg::Depth];
  logic [irn_pkg::PixW-1:0]  rd_q;
  logic [irn_pkg::PixW-1:0]  r_data_q;
  logic                      r_inside_q;
  logic                      r_valid_q, r_valid_d;
  logic                      pop_load, pop_fetch;

  // loads retire without touching the result register
  assign pop_o     = q_stat_i.valid &&
                     (item_i.op == irn_pkg::OpLoad || !r_valid_q || !out_stall_i);
  assign pop_load  = pop_o && (item_i.op == irn_pkg::OpLoad);
  assign pop_fetch = pop_o && (item_i.op == irn_pkg::OpFetch);

  always_comb begin
    r_valid_d = r_valid_q;
    if (pop_fetch) begin
      r_valid_d = 1'b1;
    end else if (r_valid_q && !out_stall_i) begin
      r_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else begin
      r_valid_q <= r_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_load) begin
      frame_mem[item_i.addr] <= item_i.data;
    end
    if (pop_fetch) begin
      rd_q <= frame_mem[item_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_fetch) begin
      r_data_q   <= item_i.data;
      r_inside_q <= item_i.in_img;
    end
  end

  assign out_valid_o = r_valid_q;
  assign out_pix_o   = r_inside_q ? rd_q : r_data_q;
  assign inside_o    = r_inside_q;

endmodule

// ----- sv/image_rotate_nearest_top.sv -----
// Nearest-neighbor image rotation over a 256 x 256 frame store of 48-bit pixels
// (three signed 16-bit channels). A load transaction (opcode 0) writes one source
// pixel at (col,row) and returns nothing; a fetch transaction (opcode 1) maps the
// output pixel (col,row) about the centre with the Q4.12 cos/sin coefficients,
// truncates toward zero and returns the stored pixel, or the fill pixel with
// inside_res low when the source lies outside the image. Sustained rate is one
// transaction per clock while the output is not stalled, set by the single frame
// store port shared by loads and fetches; a fetch result passes two front stages
// for the products and bounds and one for the store read, and is held while the
// output is stalled. Reading a store location never loaded returns undefined
// data. Registers may only be written while the block is idle.
`timescale 1ns / 1ps

module image_rotate_nearest_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [47:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                opcode_i,
  input  logic [7:0]          col_i,
  input  logic [7:0]          row_i,
  input  logic signed [15:0]  load_ch0_i,
  input  logic signed [15:0]  load_ch1_i,
  input  logic signed [15:0]  load_ch2_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [15:0]  out_ch0_o,
  output logic signed [15:0]  out_ch1_o,
  output logic signed [15:0]  out_ch2_o,
  output logic                inside_res_o
);

`include "image_rotate_nearest_top_assert.svh"

  irn_pkg::cfg_t               cfg_q, cfg_d;
  irn_pkg::q_item_t            push_item, pop_item;
  irn_pkg::q_stat_t            q_stat;
  logic                        q_push, q_pop;
  logic [irn_pkg::PixW-1:0]    out_pix;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (irn_pkg::cfg_idx_e'(cfg_index_i))
        irn_pkg::CfgCoefCos:   cfg_d.coef_cos   = cfg_data_i[irn_pkg::CoefW-1:0];
        irn_pkg::CfgCoefSin:   cfg_d.coef_sin   = cfg_data_i[irn_pkg::CoefW-1:0];
        irn_pkg::CfgCentreCol: cfg_d.centre_col = cfg_data_i[irn_pkg::PosW-1:0];
        irn_pkg::CfgCentreRow: cfg_d.centre_row = cfg_data_i[irn_pkg::PosW-1:0];
        irn_pkg::CfgImageCols: cfg_d.image_cols = cfg_data_i[irn_pkg::SizeW-1:0];
        irn_pkg::CfgImageRows: cfg_d.image_rows = cfg_data_i[irn_pkg::SizeW-1:0];
        irn_pkg::CfgFillPixel: cfg_d.fill_pixel = cfg_data_i[irn_pkg::PixW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_cos   <= irn_pkg::CoefW'(irn_pkg::FracOne);
      cfg_q.coef_sin   <= '0;
      cfg_q.centre_col <= '0;
      cfg_q.centre_row <= '0;
      cfg_q.image_cols <= irn_pkg::SizeW'(irn_pkg::MaxCols);
      cfg_q.image_rows <= irn_pkg::SizeW'(irn_pkg::MaxRows);
      cfg_q.fill_pixel <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  irn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .col_i      (col_i),
    .row_i      (row_i),
    .load_ch0_i (load_ch0_i),
    .load_ch1_i (load_ch1_i),
    .load_ch2_i (load_ch2_i),
    .q_stat_i   (q_stat),
    .push_o     (q_push),
    .item_o     (push_item)
  );

  irn_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (push_item),
    .pop_i  (q_pop),
    .item_o (pop_item),
    .stat_o (q_stat)
  );

  irn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .item_i      (pop_item),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_pix_o   (out_pix),
    .inside_o    (inside_res_o)
  );

  assign out_ch0_o = out_pix[irn_pkg::ChanW-1:0];
  assign out_ch1_o = out_pix[2*irn_pkg::ChanW-1:irn_pkg::ChanW];
  assign out_ch2_o = out_pix[3*irn_pkg::ChanW-1:2*irn_pkg::ChanW];

  // an outside result must carry the masked fill pixel
  `IRN_ASSERT_IMP(a_fill_on_outside, out_valid_o && !inside_res_o, out_pix == (cfg_q.fill_pixel & irn_pkg::ChanMask))
  // a result only appears after a fetch left the queue
  `IRN_ASSERT_IMP(a_result_from_fetch, $rose(out_valid_o), $past(q_pop && pop_item.op == irn_pkg::OpFetch))
  // queue occupancy stays within its depth
  `IRN_ASSERT_NEVER(a_queue_bound, q_stat.count > irn_pkg::QCntW'(irn_pkg::QDepth))

endmodule
